### src/swrl_pkg.sv
package swrl_pkg;

    // Fixed field widths of the ports
    localparam int CLIENT_W  = 4;
    localparam int NOW_W     = 32;
    localparam int HELD_W    = 4;
    localparam int MAXREQ_W  = 4;
    localparam int WINDOW_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

    // Register reset values
    localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 4'd5;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd60;

    // One classified request as it sits in the queue
    typedef struct packed {
        logic                in_range;
        logic [CLIENT_W-1:0] client;
        logic [NOW_W-1:0]    now;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  nonempty;
        item_t item;
    } queue_if_t;

    // Back end control toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

### src/swrl_front.sv
module swrl_front #(
    parameter int CLIENTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [swrl_pkg::CLIENT_W-1:0]       client,
    input  logic [swrl_pkg::NOW_W-1:0]          now,
    output logic                                busy,
    input  swrl_pkg::back_ctl_t                 back_ctl,
    output swrl_pkg::queue_if_t                 queue_if
);

    // Two-entry queue between front and back
    swrl_pkg::item_t q_item_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;

    logic            push;
    swrl_pkg::item_t new_item;

    // Classify: out-of-range clients are flagged here
    always_comb
    begin
        new_item.in_range = (32'(client) < CLIENTS);
        new_item.client   = client;
        new_item.now      = now;
    end

    assign busy = (fill_reg == 2'd2) || back_ctl.clearing;
    assign push = start && !busy;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (back_ctl.pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !back_ctl.pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && back_ctl.pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_item_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign queue_if.nonempty = (fill_reg != 2'd0);
    assign queue_if.item     = q_item_reg[rd_ptr_reg];

endmodule

### src/swrl_back.sv
module swrl_back #(
    parameter int CLIENTS   = 16,
    parameter int LOG_DEPTH = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [swrl_pkg::MAXREQ_W-1:0]       max_requests,
    input  logic [swrl_pkg::WINDOW_W-1:0]       window_length,
    input  swrl_pkg::queue_if_t                 queue_if,
    output swrl_pkg::back_ctl_t                 back_ctl,
    output logic                                done,
    output logic                                allowed,
    output logic [swrl_pkg::HELD_W-1:0]         held_count
);

    localparam int SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CIDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int DEPTH  = CLIENTS * LOG_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [2:0] {
        B_IDLE,
        B_REC,
        B_SCAN,
        B_TEST,
        B_DECIDE
    } state_t;

    // Memories: stamp ring per client, and per-client record
    logic [TIME_BITS-1:0] stamp_mem [DEPTH];
    logic [SLOT_W-1:0]    slot_mem  [CLIENTS];
    logic [CNT_W-1:0]     cnt_mem   [CLIENTS];

    state_t               state_reg, state_next;
    logic                 clear_reg, clear_next;
    logic [CIDX_W-1:0]    clear_idx_reg, clear_idx_next;
    logic [CIDX_W-1:0]    cidx_reg, cidx_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 done_reg, done_next;
    logic                 allowed_reg, allowed_next;
    logic [CNT_W-1:0]     held_reg, held_next;

    logic [TIME_BITS-1:0] stamp_rd_reg;
    logic [SLOT_W-1:0]    slot_rd_reg;
    logic [CNT_W-1:0]     cnt_rd_reg;

    logic                 pop;
    logic [CIDX_W-1:0]    q_cidx;
    logic [ADDR_W-1:0]    stamp_raddr;
    logic                 stamp_we;
    logic [ADDR_W-1:0]    stamp_waddr;
    logic                 rec_we;
    logic [CIDX_W-1:0]    rec_waddr;
    logic [SLOT_W-1:0]    rec_wslot;
    logic [CNT_W-1:0]     rec_wcnt;

    logic [TIME_BITS-1:0] age;
    logic                 expired;
    logic [SLOT_W-1:0]    head_inc;
    logic [SUM_W-1:0]     pos_sum;
    logic [SUM_W-1:0]     pos_wrap;
    logic                 accept;

    assign q_cidx      = CIDX_W'(queue_if.item.client);
    assign stamp_raddr = base_reg + ADDR_W'(head_reg);

    // Age test on the stamp just read
    assign age     = now_reg - stamp_rd_reg;
    assign expired = !age[TIME_BITS-1] && (CMP_W'(age) >= CMP_W'(window_length));

    // Ring position arithmetic
    assign head_inc = (head_reg == SLOT_W'(LOG_DEPTH - 1)) ? '0 : head_reg + SLOT_W'(1);
    assign pos_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign pos_wrap = (pos_sum >= SUM_W'(LOG_DEPTH)) ? pos_sum - SUM_W'(LOG_DEPTH) : pos_sum;

    // Limit is max_requests capped at the ring depth
    assign accept = (32'(count_reg) < 32'(max_requests)) && (32'(count_reg) < LOG_DEPTH);

    // Back-end sequencer
    always_comb
    begin
        state_next     = state_reg;
        clear_next     = clear_reg;
        clear_idx_next = clear_idx_reg;
        cidx_next      = cidx_reg;
        base_next      = base_reg;
        now_next       = now_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        allowed_next   = allowed_reg;
        held_next      = held_reg;
        pop            = 1'b0;
        stamp_we       = 1'b0;
        stamp_waddr    = base_reg + ADDR_W'(pos_wrap);
        rec_we         = 1'b0;
        rec_waddr      = cidx_reg;
        rec_wslot      = head_reg;
        rec_wcnt       = count_reg;

        if (clear_reg)
        begin
            // Clearing pass over the client records after reset
            rec_we    = 1'b1;
            rec_waddr = clear_idx_reg;
            rec_wslot = '0;
            rec_wcnt  = '0;
            if (clear_idx_reg == CIDX_W'(CLIENTS - 1))
            begin
                clear_next = 1'b0;
            end
            else
            begin
                clear_idx_next = clear_idx_reg + CIDX_W'(1);
            end
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (queue_if.nonempty)
                    begin
                        pop       = 1'b1;
                        cidx_next = q_cidx;
                        base_next = ADDR_W'(q_cidx) * ADDR_W'(LOG_DEPTH);
                        now_next  = TIME_BITS'(queue_if.item.now);
                        if (queue_if.item.in_range)
                        begin
                            state_next = B_REC;
                        end
                        else
                        begin
                            done_next    = 1'b1;
                            allowed_next = 1'b0;
                            held_next    = '0;
                        end
                    end
                end
                B_REC:
                begin
                    head_next  = slot_rd_reg;
                    count_next = cnt_rd_reg;
                    state_next = B_SCAN;
                end
                B_SCAN:
                begin
                    state_next = (count_reg == '0) ? B_DECIDE : B_TEST;
                end
                B_TEST:
                begin
                    if (expired)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                        state_next = B_SCAN;
                    end
                    else
                    begin
                        state_next = B_DECIDE;
                    end
                end
                B_DECIDE:
                begin
                    rec_we = 1'b1;
                    if (accept)
                    begin
                        stamp_we = 1'b1;
                        rec_wcnt = count_reg + CNT_W'(1);
                    end
                    done_next    = 1'b1;
                    allowed_next = accept;
                    held_next    = rec_wcnt;
                    state_next   = B_IDLE;
                end
                default:
                begin
                    state_next = B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            clear_reg     <= 1'b1;
            clear_idx_reg <= '0;
            done_reg      <= 1'b0;
            allowed_reg   <= 1'b0;
            held_reg      <= '0;
            cidx_reg      <= '0;
            base_reg      <= '0;
            now_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_reg     <= clear_next;
            clear_idx_reg <= clear_idx_next;
            done_reg      <= done_next;
            allowed_reg   <= allowed_next;
            held_reg      <= held_next;
            cidx_reg      <= cidx_next;
            base_reg      <= base_next;
            now_reg       <= now_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    // Stamp memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= now_reg;
        end
        stamp_rd_reg <= stamp_mem[stamp_raddr];
    end

    // Client record memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            slot_mem[rec_waddr] <= rec_wslot;
            cnt_mem[rec_waddr]  <= rec_wcnt;
        end
        slot_rd_reg <= slot_mem[q_cidx];
        cnt_rd_reg  <= cnt_mem[q_cidx];
    end

    assign back_ctl.pop      = pop;
    assign back_ctl.clearing = clear_reg;

    assign done       = done_reg;
    assign allowed    = allowed_reg;
    assign held_count = swrl_pkg::HELD_W'(held_reg);

endmodule

### src/sliding_window_rate_limiter_unit.sv
// Channel   Handshake                  Payload
// request   start & !busy              client, now
// result    done (one-cycle strobe)    allowed, held_count
// config    cfg_we                     cfg_index, cfg_data
//
// A request leaving the queue has its client record read (B_REC), then its
// expired stamps, 0..LOG_DEPTH, are dropped in B_SCAN and B_TEST until a live
// stamp or an empty ring ends the scan; each drop is a stamp read and an age
// test. Out-of-range clients skip the scan. After reset the client records
// are cleared, busy high. A two-entry queue takes requests while the back end
// works; busy is high when it is full. Results cannot be stalled.
module sliding_window_rate_limiter_unit #(
    parameter int CLIENTS   = 16,
    parameter int LOG_DEPTH = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [swrl_pkg::CLIENT_W-1:0]       client,
    input  logic [swrl_pkg::NOW_W-1:0]          now,
    output logic                                done,
    output logic                                allowed,
    output logic [swrl_pkg::HELD_W-1:0]         held_count,
    input  logic                                cfg_we,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swrl_pkg::CFG_W-1:0]          cfg_data
);

    logic [swrl_pkg::MAXREQ_W-1:0] max_requests_reg;
    logic [swrl_pkg::WINDOW_W-1:0] window_length_reg;

    swrl_pkg::queue_if_t queue_if;
    swrl_pkg::back_ctl_t back_ctl;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_requests_reg  <= swrl_pkg::MAXREQ_RESET;
            window_length_reg <= swrl_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swrl_pkg::REG_MAX_REQUESTS:
                begin
                    max_requests_reg <= cfg_data[swrl_pkg::MAXREQ_W-1:0];
                end
                swrl_pkg::REG_WINDOW_LENGTH:
                begin
                    window_length_reg <= cfg_data[swrl_pkg::WINDOW_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    swrl_front #(
        .CLIENTS (CLIENTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .client   (client),
        .now      (now),
        .busy     (busy),
        .back_ctl (back_ctl),
        .queue_if (queue_if)
    );

    swrl_back #(
        .CLIENTS   (CLIENTS),
        .LOG_DEPTH (LOG_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_requests  (max_requests_reg),
        .window_length (window_length_reg),
        .queue_if      (queue_if),
        .back_ctl      (back_ctl),
        .done          (done),
        .allowed       (allowed),
        .held_count    (held_count)
    );

endmodule
